>>> rtl/gih_pkg.sv
// ---------------------------------------------------------------------------
// gih_pkg
// Shared types, constants and arithmetic helpers for the graph hash block.
// ---------------------------------------------------------------------------
package gih_pkg;

    localparam int ROW_W         = 15;
    localparam int MAX_VERTICES_D = 15;
    localparam int CNT_W         = 4;
    localparam int TRI_W         = 8;

    localparam logic [63:0] FNV_VERTEX_START = 64'd1469598103934665603;
    localparam logic [63:0] FNV_GRAPH_START  = 64'd14695981039346656037;

    localparam logic [2:0] ADDR_VERTEX_COUNT = 3'd0;

    // The row index travels with the row, so the engine needs no count of
    // its own that a register write could leave out of step.
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [CNT_W-1:0] idx;
        logic             last;
        logic [CNT_W-1:0] n;
    } gih_entry_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_VSTART,
        ST_TRI,
        ST_FTRI,
        ST_FNB,
        ST_VINS,
        ST_GFOLD
    } gih_state_t;

    // Multiplication by the FNV prime 2^40 + 435 as a shift-add.
    function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [63:0] x);
        logic [63:0] t;
        t = h ^ x;
        return (t << 40) + (t << 8) + (t << 7) + (t << 5) + (t << 4) + (t << 1) + t;
    endfunction

    function automatic logic [CNT_W-1:0] popcount(input logic [ROW_W-1:0] x);
        logic [CNT_W-1:0] c;
        c = '0;
        for (int j = 0; j < ROW_W; j++) begin
            c = c + CNT_W'(x[j]);
        end
        return c;
    endfunction

endpackage

>>> rtl/gih_front.sv
// ---------------------------------------------------------------------------
// gih_front
// Configuration register, row masking and row counting; pushes one entry per
// accepted item into the queue.
// ---------------------------------------------------------------------------
module gih_front #(
    parameter int MAX_VERTICES = gih_pkg::MAX_VERTICES_D
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    input  logic                      start,
    input  logic [gih_pkg::ROW_W-1:0] neighbor_mask,
    input  logic                      full,
    output logic                      push,
    output gih_pkg::gih_entry_t       entry
);
    import gih_pkg::*;

    logic [CNT_W-1:0] vc_reg, vc_next;
    logic [CNT_W-1:0] rc_reg, rc_next;
    logic [CNT_W-1:0] n_act, idx;
    logic [ROW_W:0]   keep;
    logic             wr_en, last;

    assign wr_en = psel && penable && pwrite && (paddr[2] == ADDR_VERTEX_COUNT[2]);
    assign prdata = {28'd0, vc_reg};

    always_comb
    begin
        if (vc_reg == '0)
            n_act = CNT_W'(1);
        else if (32'(vc_reg) > MAX_VERTICES)
            n_act = CNT_W'(MAX_VERTICES);
        else
            n_act = vc_reg;
    end

    assign keep = (ROW_W+1)'((17'd1 << n_act) - 17'd1);
    assign idx  = (rc_reg >= n_act) ? '0 : rc_reg;
    assign last = (5'(idx) + 5'd1) >= 5'(n_act);
    assign push = start && !full;

    assign entry.row  = neighbor_mask & keep[ROW_W-1:0];
    assign entry.idx  = idx;
    assign entry.last = last;
    assign entry.n    = n_act;

    always_comb
    begin
        vc_next = vc_reg;
        rc_next = rc_reg;
        if (wr_en)
        begin
            vc_next = pwdata[CNT_W-1:0];
            rc_next = '0;
        end
        else if (push)
        begin
            rc_next = last ? '0 : idx + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= CNT_W'(15);
            rc_reg <= '0;
        end
        else
        begin
            vc_reg <= vc_next;
            rc_reg <= rc_next;
        end
    end

endmodule

>>> rtl/gih_queue.sv
// ---------------------------------------------------------------------------
// gih_queue
// Two-entry queue of row items between the front and the hash engine.
// ---------------------------------------------------------------------------
module gih_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  gih_pkg::gih_entry_t push_data,
    input  logic                pop,
    output gih_pkg::gih_entry_t pop_data,
    output logic                empty,
    output logic                full
);
    import gih_pkg::*;

    gih_entry_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       do_pop;

    assign empty    = (cnt_reg == 2'd0);
    assign full     = (cnt_reg == 2'd2);
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (do_pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(do_pop);
        end
    end

endmodule

>>> rtl/gih_back.sv
// ---------------------------------------------------------------------------
// gih_back
// Hash engine: collects rows, then walks each vertex to build its hash,
// keeps the vertex hashes in sorted order and folds them into the result.
// ---------------------------------------------------------------------------
module gih_back #(
    parameter int MAX_VERTICES = gih_pkg::MAX_VERTICES_D
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                empty,
    input  gih_pkg::gih_entry_t pop_data,
    output logic                pop,
    output logic                result_valid,
    output logic [63:0]         graph_hash
);
    import gih_pkg::*;

    localparam int IW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);

    gih_state_t       st_reg, st_next;
    logic [ROW_W-1:0] rows_reg [MAX_VERTICES];
    logic [63:0]      vh_reg   [MAX_VERTICES];
    logic [63:0]      vh_next  [MAX_VERTICES];
    logic [CNT_W-1:0] n_reg, v_reg, i_reg, d_reg;
    logic [CW-1:0]    c_reg;
    logic [ROW_W-1:0] nb_reg, rem_reg;
    logic [TRI_W-1:0] tri_reg;
    logic [63:0]      h_reg, g_reg, hash_reg;
    logic             valid_reg;

    logic [ROW_W-1:0] row_rd, above, eq, lowbit;
    logic [CNT_W-1:0] deg [ROW_W];
    logic [MAX_VERTICES-1:0] gt;
    logic             last_v, last_i, last_a;

    assign pop          = (st_reg == ST_LOAD);
    assign result_valid = valid_reg;
    assign graph_hash   = hash_reg;

    assign row_rd = rows_reg[IW'((st_reg == ST_VSTART) ? v_reg : i_reg)];
    assign above  = 15'h7FFF << (5'(i_reg) + 5'd1);
    assign lowbit = eq & (~eq + 15'd1);
    assign last_v = (5'(v_reg) + 5'd1) == 5'(n_reg);
    assign last_i = (5'(i_reg) + 5'd1) == 5'(n_reg);
    assign last_a = last_i;

    genvar j;
    generate
        for (j = 0; j < ROW_W; j++)
        begin : g_deg
            if (j < MAX_VERTICES)
            begin : g_on
                assign deg[j] = popcount(rows_reg[j]);
            end
            else
            begin : g_off
                assign deg[j] = '0;
            end
            assign eq[j] = rem_reg[j] && (deg[j] == d_reg);
        end
    endgenerate

    // Sorted insertion: entries above the new hash move up by one place.
    genvar k;
    generate
        for (k = 0; k < MAX_VERTICES; k++)
        begin : g_ins
            assign gt[k] = (CW'(k) < c_reg) && (vh_reg[k] > h_reg);
            if (k == 0)
            begin : g_first
                always_comb
                begin
                    if (CW'(k) < c_reg && !gt[k])
                        vh_next[k] = vh_reg[k];
                    else
                        vh_next[k] = h_reg;
                end
            end
            else
            begin : g_rest
                always_comb
                begin
                    if (CW'(k) < c_reg && !gt[k])
                        vh_next[k] = vh_reg[k];
                    else if (CW'(k) <= c_reg && gt[k-1])
                        vh_next[k] = vh_reg[k-1];
                    else
                        vh_next[k] = h_reg;
                end
            end
        end
    endgenerate

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_LOAD:   if (!empty && pop_data.last) st_next = ST_VSTART;
            ST_VSTART: st_next = ST_TRI;
            ST_TRI:    if (last_i) st_next = ST_FTRI;
            ST_FTRI:   st_next = ST_FNB;
            ST_FNB:    if (rem_reg == '0) st_next = ST_VINS;
            ST_VINS:   st_next = last_v ? ST_GFOLD : ST_VSTART;
            ST_GFOLD:  if (last_a) st_next = ST_LOAD;
            default:   st_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= ST_LOAD;
            c_reg     <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            valid_reg <= (st_reg == ST_GFOLD) && last_a;
            if (st_reg == ST_LOAD)
                c_reg <= '0;
            else if (st_reg == ST_VINS)
                c_reg <= c_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (st_reg)
            ST_LOAD:
            begin
                if (!empty)
                begin
                    rows_reg[IW'(pop_data.idx)] <= pop_data.row;
                    n_reg <= pop_data.n;
                end
                v_reg <= '0;
            end
            ST_VSTART:
            begin
                nb_reg  <= row_rd;
                rem_reg <= row_rd;
                h_reg   <= fnv_fold(FNV_VERTEX_START, 64'(popcount(row_rd)));
                tri_reg <= '0;
                i_reg   <= '0;
                d_reg   <= '0;
            end
            ST_TRI:
            begin
                if (nb_reg[i_reg])
                    tri_reg <= tri_reg + TRI_W'(popcount(row_rd & nb_reg & above));
                i_reg <= i_reg + CNT_W'(1);
            end
            ST_FTRI:
            begin
                h_reg <= fnv_fold(h_reg, 64'(tri_reg));
            end
            ST_FNB:
            begin
                // Neighbour degrees come out in ascending order by scanning d.
                if (eq == '0)
                    d_reg <= d_reg + CNT_W'(1);
                else
                begin
                    h_reg   <= fnv_fold(h_reg, 64'(d_reg));
                    rem_reg <= rem_reg & ~lowbit;
                end
            end
            ST_VINS:
            begin
                for (int m = 0; m < MAX_VERTICES; m++)
                    vh_reg[m] <= vh_next[m];
                v_reg <= v_reg + CNT_W'(1);
                i_reg <= '0;
                g_reg <= FNV_GRAPH_START;
            end
            ST_GFOLD:
            begin
                g_reg    <= fnv_fold(g_reg, vh_reg[IW'(i_reg)]);
                hash_reg <= fnv_fold(g_reg, vh_reg[IW'(i_reg)]);
                i_reg    <= i_reg + CNT_W'(1);
            end
            default:
            begin
                v_reg <= '0;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_result_ends_graph: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (st_reg == ST_LOAD && $past(st_reg) == ST_GFOLD))
        else $error("result outside the final fold");
    a_tri_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_TRI) |-> (5'(i_reg) < 5'(n_reg)))
        else $error("triangle index beyond vertex count");
    a_sorted_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_VINS) |-> (32'(c_reg) < MAX_VERTICES))
        else $error("sorted hash list overflow");
    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != ST_LOAD) |=> (st_reg != ST_LOAD || $past(st_reg) == ST_GFOLD))
        else $error("engine returned to loading mid graph");
`endif

endmodule

>>> rtl/graph_invariant_hash.sv
// ---------------------------------------------------------------------------
// graph_invariant_hash
// Isomorphism-invariant 64-bit hash of an undirected graph loaded row by row.
// ---------------------------------------------------------------------------
// Rows are taken one item per start pulse while busy is low; the item that
// completes vertex_count rows yields one hash on graph_hash, marked by a
// one-cycle result_valid strobe that the receiver cannot hold off. Rows go
// through a two-entry queue into the hash engine, which takes one row per
// cycle while loading and takes no rows while it hashes the n vertices:
// per vertex a triangle pass over n rows, a degree scan and a sorted
// insertion, then one fold per vertex hash. Busy stays high while the
// queue is full behind the engine.
module graph_invariant_hash #(
    parameter int MAX_VERTICES = gih_pkg::MAX_VERTICES_D
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      start,
    output logic                      busy,
    input  logic [gih_pkg::ROW_W-1:0] neighbor_mask,
    output logic                      result_valid,
    output logic [63:0]               graph_hash
);
    import gih_pkg::*;

    gih_entry_t push_data, pop_data;
    logic       push, pop, empty, full;

    assign pready = 1'b1;
    assign busy   = full;

    gih_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
        .start, .neighbor_mask, .full, .push, .entry(push_data)
    );

    gih_queue u_queue (
        .clk, .rst_n, .push, .push_data, .pop, .pop_data, .empty, .full
    );

    gih_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
        .clk, .rst_n, .empty, .pop_data, .pop, .result_valid, .graph_hash
    );

endmodule
